FILE: hdl/divider_128bit_signed_unsigned_top_macros.svh
// Assertion macros shared by the divider RTL.
// Included by dvs_core.sv and divider_128bit_signed_unsigned_top.sv.
`ifndef DIVIDER_128BIT_SIGNED_UNSIGNED_TOP_MACROS_SVH
`define DIVIDER_128BIT_SIGNED_UNSIGNED_TOP_MACROS_SVH

// same-cycle implication
`define DVS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DVS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/dvs_pkg.sv
// Package for the 128-bit divider: widths, payload structs, FSM states.
// No dependencies.
`timescale 1ns / 1ps
package dvs_pkg;

  localparam int unsigned W     = 128;
  localparam int unsigned HW    = 64;
  localparam int unsigned CNT_W = $clog2(W);

  typedef struct packed {
    logic          command;
    logic [HW-1:0] dividend_hi;
    logic [HW-1:0] dividend_lo;
    logic [HW-1:0] divisor_hi;
    logic [HW-1:0] divisor_lo;
  } in_t;

  typedef struct packed {
    logic [HW-1:0] quotient_hi;
    logic [HW-1:0] quotient_lo;
    logic [HW-1:0] remainder_hi;
    logic [HW-1:0] remainder_lo;
    logic          divide_by_zero;
  } out_t;

  localparam logic CMD_UNSIGNED = 1'b0;
  localparam logic CMD_SIGNED   = 1'b1;

  typedef struct packed {
    logic start;
  } core_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } core_sts_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_NEG_N,
    S_NEG_D,
    S_WAIT,
    S_FIX_Q,
    S_FIX_R,
    S_DONE
  } state_t;

endpackage

FILE: hdl/dvs_core.sv
// Iterative restoring divider core: one quotient bit per cycle, unsigned.
// Depends on dvs_pkg and divider_128bit_signed_unsigned_top_macros.svh.
`timescale 1ns / 1ps
module dvs_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  dvs_pkg::core_ctl_t           ctl,
  input  logic [dvs_pkg::W-1:0]        num,
  input  logic [dvs_pkg::W-1:0]        den,
  output dvs_pkg::core_sts_t           sts,
  output logic [dvs_pkg::W-1:0]        quo,
  output logic [dvs_pkg::W-1:0]        rem
);
  import dvs_pkg::*;
  `include "divider_128bit_signed_unsigned_top_macros.svh"

  logic [W-1:0]     rem_r, rem_nxt;
  logic [W-1:0]     quo_r, quo_nxt;
  logic [W-1:0]     den_r, den_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [W:0]       trial;
  logic             last;

  assign trial = {rem_r, quo_r[W-1]} - {1'b0, den_r};
  assign last  = (cnt_r == CNT_W'(W - 1));

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (ctl.start) begin
      rem_nxt  = '0;
      quo_nxt  = num;
      den_nxt  = den;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // no borrow: subtract fits, quotient bit set
      if (!trial[W]) begin
        rem_nxt = trial[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[W-2:0], quo_r[W-1]};
        quo_nxt = {quo_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + CNT_W'(1);
      if (last) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quo      = quo_r;
  assign rem      = rem_r;

  `DVS_ASSERT_IMP(a_start_idle, clk, rst_n, ctl.start, !busy_r, "start while core busy")
  `DVS_ASSERT_IMP(a_done_idle, clk, rst_n, done_r, !busy_r, "done while core busy")
  `DVS_ASSERT_NXT(a_last_done, clk, rst_n, busy_r && last && !ctl.start, done_r,
                  "last step without done")

endmodule

FILE: hdl/divider_128bit_signed_unsigned_top.sv
// Top level of the 128-bit signed/unsigned divider: sequencer, shared negator,
// output register. Depends on dvs_pkg, dvs_core and the macros header.
//
//   port group   dir  handshake             payload
//   in_*         in   in_valid / in_ready   dvs_pkg::in_t
//   out_*        out  out_valid / out_ready dvs_pkg::out_t
//
// From input transfer to out_valid an item passes two negate steps, 128
// restoring steps in dvs_core, handoff, two sign fixups and the load.
// Zero divisor skips the core: the FSM goes from idle straight to the load state.
// in_ready is high only in idle; a result held by out_ready low does not block
// the next transfer until that item is ready to load. Reset is synchronous.
`timescale 1ns / 1ps
module divider_128bit_signed_unsigned_top (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  dvs_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output dvs_pkg::out_t  out_data
);
  import dvs_pkg::*;
  `include "divider_128bit_signed_unsigned_top_macros.svh"

  state_t       state_r, state_nxt;
  logic [W-1:0] num_r, num_nxt;
  logic [W-1:0] den_r, den_nxt;
  logic [W-1:0] q_r, q_nxt;
  logic [W-1:0] r_r, r_nxt;
  logic         sgn_r, sgn_nxt;
  logic         num_neg_r, num_neg_nxt;
  logic         den_neg_r, den_neg_nxt;
  logic         dz_r, dz_nxt;
  out_t         out_r, out_nxt;
  logic         out_valid_r, out_valid_nxt;

  logic [W-1:0] neg_in, neg_out;
  logic [W-1:0] in_num, in_den;
  core_ctl_t    core_ctl;
  core_sts_t    core_sts;
  logic [W-1:0] core_quo, core_rem;
  logic [W-1:0] core_den;
  logic         in_xfer;

  assign in_num  = {in_data.dividend_hi, in_data.dividend_lo};
  assign in_den  = {in_data.divisor_hi, in_data.divisor_lo};
  assign in_ready = (state_r == S_IDLE);
  assign in_xfer  = in_valid && in_ready;

  // shared negator
  always_comb begin
    case (state_r)
      S_NEG_N: neg_in = num_r;
      S_NEG_D: neg_in = den_r;
      S_FIX_Q: neg_in = q_r;
      default: neg_in = r_r;
    endcase
  end
  assign neg_out = ~neg_in + W'(1);

  assign core_den = den_neg_r ? neg_out : den_r;

  dvs_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (core_ctl),
    .num   (num_r),
    .den   (core_den),
    .sts   (core_sts),
    .quo   (core_quo),
    .rem   (core_rem)
  );

  always_comb begin
    state_nxt     = state_r;
    num_nxt       = num_r;
    den_nxt       = den_r;
    q_nxt         = q_r;
    r_nxt         = r_r;
    sgn_nxt       = sgn_r;
    num_neg_nxt   = num_neg_r;
    den_neg_nxt   = den_neg_r;
    dz_nxt        = dz_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    core_ctl      = '0;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          num_nxt     = in_num;
          den_nxt     = in_den;
          sgn_nxt     = (in_data.command == CMD_SIGNED);
          num_neg_nxt = (in_data.command == CMD_SIGNED) && in_data.dividend_hi[HW-1];
          den_neg_nxt = (in_data.command == CMD_SIGNED) && in_data.divisor_hi[HW-1];
          dz_nxt      = (in_den == '0);
          if (in_den == '0) begin
            q_nxt     = '0;
            r_nxt     = in_num;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_NEG_N;
          end
        end
      end
      S_NEG_N: begin
        if (num_neg_r) num_nxt = neg_out;
        state_nxt = S_NEG_D;
      end
      S_NEG_D: begin
        core_ctl.start = 1'b1;
        state_nxt      = S_WAIT;
      end
      S_WAIT: begin
        if (core_sts.done) begin
          q_nxt     = core_quo;
          r_nxt     = core_rem;
          state_nxt = S_FIX_Q;
        end
      end
      S_FIX_Q: begin
        if (sgn_r && (num_neg_r != den_neg_r)) q_nxt = neg_out;
        state_nxt = S_FIX_R;
      end
      S_FIX_R: begin
        if (sgn_r && num_neg_r) r_nxt = neg_out;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_nxt.quotient_hi    = q_r[W-1:HW];
          out_nxt.quotient_lo    = q_r[HW-1:0];
          out_nxt.remainder_hi   = r_r[W-1:HW];
          out_nxt.remainder_lo   = r_r[HW-1:0];
          out_nxt.divide_by_zero = dz_r;
          out_valid_nxt          = 1'b1;
          state_nxt              = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r     <= num_nxt;
    den_r     <= den_nxt;
    q_r       <= q_nxt;
    r_r       <= r_nxt;
    sgn_r     <= sgn_nxt;
    num_neg_r <= num_neg_nxt;
    den_neg_r <= den_neg_nxt;
    dz_r      <= dz_nxt;
    out_r     <= out_nxt;
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `DVS_ASSERT_NXT(a_dz_skip, clk, rst_n, in_xfer && (in_den == '0), state_r == S_DONE,
                  "zero divisor did not skip the core")
  `DVS_ASSERT_IMP(a_busy_wait, clk, rst_n, core_sts.busy, state_r == S_WAIT,
                  "core busy outside wait state")
  `DVS_ASSERT_IMP(a_dz_quot, clk, rst_n, out_valid_r && out_r.divide_by_zero,
                  out_r.quotient_hi == '0 && out_r.quotient_lo == '0,
                  "nonzero quotient on divide by zero")

endmodule
